// File: rtl/dvps_pkg.sv
// dvps_pkg: shared constants, register indexes, report codes and item types
// for the drain valve preheat sequencer. No dependencies.
package dvps_pkg;

    localparam int HOURS_KEPT  = 24;
    localparam int DRAIN_SLOTS = 2;

    localparam int STAMP_W    = 32;
    localparam int HOUR_W     = 5;
    localparam int MIN_W      = 6;
    localparam int SEC_W      = 6;
    localparam int TOD_W      = HOUR_W + MIN_W + SEC_W;
    localparam int TEMP_W     = 12;
    localparam int MS_W       = 27;
    localparam int REPORT_W   = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 27;

    localparam logic [CFG_IDX_W-1:0] CFG_DRAIN_TIME_A     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DRAIN_TIME_B     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COLD_LIMIT       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CRITICAL_LIMIT   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_PREHEAT_TARGET   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_PREHEAT_TIMEOUT  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_DRAIN_OPEN       = 3'd6;

    localparam logic [REPORT_W-1:0] REPORT_NONE    = 2'd0;
    localparam logic [REPORT_W-1:0] REPORT_TIMEOUT = 2'd1;
    localparam logic [REPORT_W-1:0] REPORT_COLD    = 2'd2;

    localparam logic signed [TEMP_W-1:0] RST_COLD_LIMIT     = 12'sd0;
    localparam logic signed [TEMP_W-1:0] RST_CRITICAL_LIMIT = -12'sd80;
    localparam logic signed [TEMP_W-1:0] RST_PREHEAT_TARGET = 12'sd80;
    localparam logic [MS_W-1:0]          RST_PREHEAT_TIMEOUT = 27'd3600000;
    localparam logic [MS_W-1:0]          RST_DRAIN_OPEN      = 27'd10000;

    typedef struct packed {
        logic [TOD_W-1:0]         drain_time_a;
        logic [TOD_W-1:0]         drain_time_b;
        logic signed [TEMP_W-1:0] cold_limit;
        logic signed [TEMP_W-1:0] critical_limit;
        logic signed [TEMP_W-1:0] preheat_target;
        logic [MS_W-1:0]          preheat_timeout_ms;
        logic [MS_W-1:0]          drain_open_ms;
    } cfg_t;

    typedef struct packed {
        logic [STAMP_W-1:0]       now_ms;
        logic [HOUR_W-1:0]        hour;
        logic [MIN_W-1:0]         minute;
        logic [SEC_W-1:0]         second;
        logic signed [TEMP_W-1:0] valve_temp;
        logic                     drain_request;
    } tick_t;

    typedef struct packed {
        logic                drain_valve_on;
        logic                preheater_on;
        logic                drain_busy;
        logic                history_clear;
        logic [REPORT_W-1:0] report;
    } result_t;

endpackage

// File: rtl/dvps_history.sv
// dvps_history: 24-hour cold-hour history, sampled once per whole hour.
// Depends on dvps_pkg.
module dvps_history (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              fire,
    input  logic [dvps_pkg::HOUR_W-1:0]       hour,
    input  logic [dvps_pkg::MIN_W-1:0]        minute,
    input  logic [dvps_pkg::SEC_W-1:0]        second,
    input  logic signed [dvps_pkg::TEMP_W-1:0] valve_temp,
    input  logic signed [dvps_pkg::TEMP_W-1:0] cold_limit,
    output logic                              history_clear
);
    import dvps_pkg::*;

    logic [HOURS_KEPT-1:0] marks_reg;
    logic [HOURS_KEPT-1:0] marks_next;
    logic                  sampled_reg;
    logic                  sampled_next;
    logic                  top_of_hour;
    logic                  is_cold;

    assign top_of_hour = (minute == '0) && (second == '0);
    assign is_cold     = valve_temp < cold_limit;

    always_comb
    begin
        marks_next   = marks_reg;
        sampled_next = sampled_reg;
        if (top_of_hour)
        begin
            if (!sampled_reg)
            begin
                sampled_next = 1'b1;
                for (int i = 0; i < HOURS_KEPT; i++)
                begin
                    if (hour == HOUR_W'(i))
                    begin
                        marks_next[i] = is_cold;
                    end
                end
            end
        end
        else
        begin
            sampled_next = 1'b0;
        end
    end

    assign history_clear = (marks_next == '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            marks_reg   <= HOURS_KEPT'(1);
            sampled_reg <= 1'b0;
        end
        else if (fire)
        begin
            marks_reg   <= marks_next;
            sampled_reg <= sampled_next;
        end
    end

`ifndef ASSERT_OFF
    a_marks_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !fire |=> $stable(marks_reg))
        else $error("history changed without an item");
    a_sample_rearm: assert property (@(posedge clk) disable iff (!rst_n)
        fire && !top_of_hour |=> !sampled_reg)
        else $error("hour sample not rearmed");
    a_single_sample: assert property (@(posedge clk) disable iff (!rst_n)
        fire && top_of_hour && sampled_reg |=> $stable(marks_reg))
        else $error("second sample taken within the same hour");
`endif

endmodule

// File: rtl/dvps_task.sv
// dvps_task: drain task, preheater and valve timing; forms each result item.
// Depends on dvps_pkg.
module dvps_task (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              fire,
    input  dvps_pkg::tick_t   tick,
    input  logic              history_clear,
    input  dvps_pkg::cfg_t    cfg,
    output dvps_pkg::result_t res
);
    import dvps_pkg::*;

    logic               task_reg, task_next;
    logic               busy_reg, busy_next;
    logic               valve_reg, valve_next;
    logic               preheat_reg, preheat_next;
    logic               cold_rep_reg, cold_rep_next;
    logic               to_rep_reg, to_rep_next;
    logic [STAMP_W-1:0] vstart_reg, vstart_next;
    logic [STAMP_W-1:0] pstart_reg, pstart_next;
    logic [REPORT_W-1:0] report;

    logic [TOD_W-1:0]         tod;
    logic                     match;
    logic                     start;
    logic signed [TEMP_W-1:0] temp;
    logic signed [TEMP_W-1:0] crit;
    logic signed [TEMP_W-1:0] target;
    logic [STAMP_W-1:0]       pre_elapsed;
    logic [STAMP_W-1:0]       valve_elapsed;

    assign tod   = {tick.hour, tick.minute, tick.second};
    assign match = (tod == cfg.drain_time_a) ||
                   ((DRAIN_SLOTS >= 2) && (tod == cfg.drain_time_b));
    assign start  = match || tick.drain_request || task_reg;
    assign temp   = tick.valve_temp;
    assign crit   = cfg.critical_limit;
    assign target = cfg.preheat_target;

    always_comb
    begin
        task_next     = task_reg;
        busy_next     = busy_reg;
        valve_next    = valve_reg;
        preheat_next  = preheat_reg;
        cold_rep_next = cold_rep_reg;
        to_rep_next   = to_rep_reg;
        vstart_next   = vstart_reg;
        pstart_next   = pstart_reg;
        report        = REPORT_NONE;
        pre_elapsed   = '0;
        if (start)
        begin
            task_next = 1'b1;
            if (!task_reg)
            begin
                busy_next = 1'b1;
            end
            if (history_clear)
            begin
                cold_rep_next = 1'b0;
                to_rep_next   = 1'b0;
                vstart_next   = tick.now_ms;
                valve_next    = 1'b1;
                task_next     = 1'b0;
            end
            else if (temp > crit)
            begin
                if (!preheat_reg)
                begin
                    pstart_next  = tick.now_ms;
                    preheat_next = 1'b1;
                end
                pre_elapsed = tick.now_ms - pstart_next;
                if (temp >= target)
                begin
                    vstart_next  = tick.now_ms;
                    valve_next   = 1'b1;
                    preheat_next = 1'b0;
                    task_next    = 1'b0;
                end
                else if (pre_elapsed > {{(STAMP_W-MS_W){1'b0}}, cfg.preheat_timeout_ms})
                begin
                    if (!to_rep_reg)
                    begin
                        to_rep_next = 1'b1;
                        report      = REPORT_TIMEOUT;
                    end
                    preheat_next = 1'b0;
                    task_next    = 1'b0;
                    busy_next    = 1'b0;
                end
            end
            else
            begin
                if (!cold_rep_reg)
                begin
                    cold_rep_next = 1'b1;
                    report        = REPORT_COLD;
                end
                task_next = 1'b0;
                busy_next = 1'b0;
            end
        end
        valve_elapsed = tick.now_ms - vstart_next;
        if (valve_next &&
            (valve_elapsed >= {{(STAMP_W-MS_W){1'b0}}, cfg.drain_open_ms}))
        begin
            valve_next = 1'b0;
            busy_next  = 1'b0;
        end
    end

    assign res.drain_valve_on = valve_next;
    assign res.preheater_on   = preheat_next;
    assign res.drain_busy     = busy_next;
    assign res.history_clear  = history_clear;
    assign res.report         = report;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            task_reg     <= 1'b0;
            busy_reg     <= 1'b0;
            valve_reg    <= 1'b0;
            preheat_reg  <= 1'b0;
            cold_rep_reg <= 1'b0;
            to_rep_reg   <= 1'b0;
            vstart_reg   <= '0;
            pstart_reg   <= '0;
        end
        else if (fire)
        begin
            task_reg     <= task_next;
            busy_reg     <= busy_next;
            valve_reg    <= valve_next;
            preheat_reg  <= preheat_next;
            cold_rep_reg <= cold_rep_next;
            to_rep_reg   <= to_rep_next;
            vstart_reg   <= vstart_next;
            pstart_reg   <= pstart_next;
        end
    end

`ifndef ASSERT_OFF
    a_timeout_flag: assert property (@(posedge clk) disable iff (!rst_n)
        fire && (report == REPORT_TIMEOUT) |=> to_rep_reg && !preheat_reg)
        else $error("timeout report without flag or with preheater left on");
    a_cold_flag: assert property (@(posedge clk) disable iff (!rst_n)
        fire && (report == REPORT_COLD) |=> cold_rep_reg && !task_reg)
        else $error("cold report without flag or with task still running");
    a_valve_rise: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(valve_reg) |-> $past(fire))
        else $error("valve opened without an item");
    a_clear_rearm: assert property (@(posedge clk) disable iff (!rst_n)
        fire && start && history_clear |=> !cold_rep_reg && !to_rep_reg)
        else $error("report flags kept after a clear-history opening");
`endif

endmodule

// File: rtl/drain_valve_preheat_sequencer_unit.sv
// drain_valve_preheat_sequencer_unit: top level; input stage, config registers,
// result register. Depends on dvps_pkg, dvps_history, dvps_task.
//
//  channel   handshake              payload
//  -------   ---------------------  ---------------------------------------------
//  in        in_valid / in_ready    now_ms hour minute second valve_temp
//                                   drain_request
//  out       out_valid / out_ready  drain_valve_on preheater_on drain_busy
//                                   history_clear report
//  cfg       cfg_we                 cfg_index cfg_data
//
// One item per cycle sustained while out_ready stays high; each item passes the input
// register, then the history and task logic into the result register.
// Reset: history holds hour 0 marked cold, all flags clear, config at defaults.
// A stalled output holds its item while one further item waits in the input
// register; in_ready then drops until out_ready returns.
module drain_valve_preheat_sequencer_unit (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic [dvps_pkg::STAMP_W-1:0]         now_ms,
    input  logic [dvps_pkg::HOUR_W-1:0]          hour,
    input  logic [dvps_pkg::MIN_W-1:0]           minute,
    input  logic [dvps_pkg::SEC_W-1:0]           second,
    input  logic signed [dvps_pkg::TEMP_W-1:0]   valve_temp,
    input  logic                                 drain_request,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic                                 drain_valve_on,
    output logic                                 preheater_on,
    output logic                                 drain_busy,
    output logic                                 history_clear,
    output logic [dvps_pkg::REPORT_W-1:0]        report,
    input  logic                                 cfg_we,
    input  logic [dvps_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [dvps_pkg::CFG_DATA_W-1:0]      cfg_data
);
    import dvps_pkg::*;

    cfg_t    cfg_reg;
    tick_t   tick_reg;
    logic    s1_valid_reg;
    logic    out_valid_reg;
    result_t res_reg;
    result_t res_next;
    logic    s2_free;
    logic    fire;
    logic    in_take;
    logic    clear;

    assign s2_free  = !out_valid_reg || out_ready;
    assign fire     = s1_valid_reg && s2_free;
    assign in_ready = !s1_valid_reg || s2_free;
    assign in_take  = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.drain_time_a       <= '0;
            cfg_reg.drain_time_b       <= '0;
            cfg_reg.cold_limit         <= RST_COLD_LIMIT;
            cfg_reg.critical_limit     <= RST_CRITICAL_LIMIT;
            cfg_reg.preheat_target     <= RST_PREHEAT_TARGET;
            cfg_reg.preheat_timeout_ms <= RST_PREHEAT_TIMEOUT;
            cfg_reg.drain_open_ms      <= RST_DRAIN_OPEN;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_DRAIN_TIME_A:    cfg_reg.drain_time_a       <= cfg_data[TOD_W-1:0];
                CFG_DRAIN_TIME_B:    cfg_reg.drain_time_b       <= cfg_data[TOD_W-1:0];
                CFG_COLD_LIMIT:      cfg_reg.cold_limit         <= cfg_data[TEMP_W-1:0];
                CFG_CRITICAL_LIMIT:  cfg_reg.critical_limit     <= cfg_data[TEMP_W-1:0];
                CFG_PREHEAT_TARGET:  cfg_reg.preheat_target     <= cfg_data[TEMP_W-1:0];
                CFG_PREHEAT_TIMEOUT: cfg_reg.preheat_timeout_ms <= cfg_data[MS_W-1:0];
                CFG_DRAIN_OPEN:      cfg_reg.drain_open_ms      <= cfg_data[MS_W-1:0];
                default:             cfg_reg                    <= cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_take)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (fire)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            tick_reg.now_ms        <= now_ms;
            tick_reg.hour          <= hour;
            tick_reg.minute        <= minute;
            tick_reg.second        <= second;
            tick_reg.valve_temp    <= valve_temp;
            tick_reg.drain_request <= drain_request;
        end
        if (fire)
        begin
            res_reg <= res_next;
        end
    end

    dvps_history u_history (
        .clk           (clk),
        .rst_n         (rst_n),
        .fire          (fire),
        .hour          (tick_reg.hour),
        .minute        (tick_reg.minute),
        .second        (tick_reg.second),
        .valve_temp    (tick_reg.valve_temp),
        .cold_limit    (cfg_reg.cold_limit),
        .history_clear (clear)
    );

    dvps_task u_task (
        .clk           (clk),
        .rst_n         (rst_n),
        .fire          (fire),
        .tick          (tick_reg),
        .history_clear (clear),
        .cfg           (cfg_reg),
        .res           (res_next)
    );

    assign out_valid      = out_valid_reg;
    assign drain_valve_on = res_reg.drain_valve_on;
    assign preheater_on   = res_reg.preheater_on;
    assign drain_busy     = res_reg.drain_busy;
    assign history_clear  = res_reg.history_clear;
    assign report         = res_reg.report;

`ifndef ASSERT_OFF
    a_ready_low: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> s1_valid_reg && out_valid_reg)
        else $error("input stalled with a free stage");
    a_take_holds: assert property (@(posedge clk) disable iff (!rst_n)
        in_take |=> s1_valid_reg)
        else $error("accepted item lost from input stage");
    a_fire_out: assert property (@(posedge clk) disable iff (!rst_n)
        fire |=> out_valid_reg)
        else $error("processed item not presented");
`endif

endmodule

// File: verif/drain_valve_preheat_sequencer_unit_tb.sv
// Self-checking testbench for drain_valve_preheat_sequencer_unit: directed and random
// ticks, register settings changed between phases, results checked against a predictor.
// Depends on dvps_pkg and the RTL of the unit only.
module drain_valve_preheat_sequencer_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import dvps_pkg::*;

    localparam int TEMP_MIN    = -880;
    localparam int TEMP_MAX    = 2000;
    localparam int TOD_MAX     = 98043;
    localparam int MS_MAX      = 86400000;
    localparam int CYCLE_LIMIT = 500000;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     in_valid = 1'b0;
    logic                     in_ready;
    logic [STAMP_W-1:0]       now_ms = '0;
    logic [HOUR_W-1:0]        hour = '0;
    logic [MIN_W-1:0]         minute = '0;
    logic [SEC_W-1:0]         second = '0;
    logic signed [TEMP_W-1:0] valve_temp = '0;
    logic                     drain_request = 1'b0;
    logic                     out_valid;
    logic                     out_ready = 1'b0;
    logic                     drain_valve_on;
    logic                     preheater_on;
    logic                     drain_busy;
    logic                     history_clear;
    logic [REPORT_W-1:0]      report;
    logic                     cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]     cfg_index = '0;
    logic [CFG_DATA_W-1:0]    cfg_data = '0;

    // predictor state and register shadow
    cfg_t                  regs;
    logic [HOURS_KEPT-1:0] cold_marks;
    logic                  hour_done, task_on, valve_on, heat_on;
    logic                  cold_told, late_told, busy;
    logic [STAMP_W-1:0]    valve_t0, heat_t0;

    result_t      results_due[$];
    logic [31:0]  wall_ms = '0;
    bit           calm = 1'b0;
    int           mismatches = 0;
    int           cycles = 0;
    int           ticks_sent = 0;

    drain_valve_preheat_sequencer_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .now_ms        (now_ms),
        .hour          (hour),
        .minute        (minute),
        .second        (second),
        .valve_temp    (valve_temp),
        .drain_request (drain_request),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .drain_valve_on(drain_valve_on),
        .preheater_on  (preheater_on),
        .drain_busy    (drain_busy),
        .history_clear (history_clear),
        .report        (report),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        out_ready <= calm || ($urandom_range(0, 99) >= 13);
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    function automatic string result_text(result_t r);
        return $sformatf("valve %0b heater %0b busy %0b clear %0b report %0d",
            r.drain_valve_on, r.preheater_on, r.drain_busy, r.history_clear, r.report);
    endfunction

    always @(posedge clk)
    begin : check_results
        result_t got;
        result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            got = {drain_valve_on, preheater_on, drain_busy, history_clear, report};
            if (results_due.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result with no tick outstanding: %s", result_text(got));
            end
            else
            begin
                want = results_due.pop_front();
                if (got !== want)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch at %0t: expected %s, got %s",
                            $realtime, result_text(want), result_text(got));
                end
            end
        end
    end

    task automatic clear_sequencer_state();
        regs.drain_time_a       = '0;
        regs.drain_time_b       = '0;
        regs.cold_limit         = RST_COLD_LIMIT;
        regs.critical_limit     = RST_CRITICAL_LIMIT;
        regs.preheat_target     = RST_PREHEAT_TARGET;
        regs.preheat_timeout_ms = RST_PREHEAT_TIMEOUT;
        regs.drain_open_ms      = RST_DRAIN_OPEN;
        cold_marks = HOURS_KEPT'(1);
        hour_done  = 1'b0;
        task_on    = 1'b0;
        valve_on   = 1'b0;
        heat_on    = 1'b0;
        cold_told  = 1'b0;
        late_told  = 1'b0;
        busy       = 1'b0;
        valve_t0   = '0;
        heat_t0    = '0;
    endtask

    // one tick through the drain sequencer; returns the outputs after it
    function automatic result_t advance_sequencer(tick_t t);
        result_t            r;
        logic [TOD_W-1:0]   tod;
        logic [STAMP_W-1:0] elapsed;
        logic               all_warm;
        logic               start;
        r   = '0;
        tod = {t.hour, t.minute, t.second};
        if (t.minute == 0 && t.second == 0)
        begin
            if (!hour_done)
            begin
                hour_done = 1'b1;
                if (t.hour < HOURS_KEPT)
                    cold_marks[t.hour] = (t.valve_temp < regs.cold_limit);
            end
        end
        else
            hour_done = 1'b0;
        all_warm = (cold_marks == '0);
        start = (tod == regs.drain_time_a) || (DRAIN_SLOTS >= 2 && tod == regs.drain_time_b);
        r.report = REPORT_NONE;
        if (start || t.drain_request || task_on)
        begin
            if (!task_on)
            begin
                task_on = 1'b1;
                busy    = 1'b1;
            end
            if (all_warm)
            begin
                cold_told = 1'b0;
                late_told = 1'b0;
                valve_t0  = t.now_ms;
                valve_on  = 1'b1;
                task_on   = 1'b0;
            end
            else if (t.valve_temp > regs.critical_limit)
            begin
                if (!heat_on)
                begin
                    heat_t0 = t.now_ms;
                    heat_on = 1'b1;
                end
                elapsed = t.now_ms - heat_t0;
                if (t.valve_temp >= regs.preheat_target)
                begin
                    valve_t0 = t.now_ms;
                    valve_on = 1'b1;
                    heat_on  = 1'b0;
                    task_on  = 1'b0;
                end
                else if (elapsed > regs.preheat_timeout_ms)
                begin
                    if (!late_told)
                    begin
                        late_told = 1'b1;
                        r.report  = REPORT_TIMEOUT;
                    end
                    heat_on = 1'b0;
                    task_on = 1'b0;
                    busy    = 1'b0;
                end
            end
            else
            begin
                if (!cold_told)
                begin
                    cold_told = 1'b1;
                    r.report  = REPORT_COLD;
                end
                task_on = 1'b0;
                busy    = 1'b0;
            end
        end
        elapsed = t.now_ms - valve_t0;
        if (valve_on && elapsed >= regs.drain_open_ms)
        begin
            valve_on = 1'b0;
            busy     = 1'b0;
        end
        r.drain_valve_on = valve_on;
        r.preheater_on   = heat_on;
        r.drain_busy     = busy;
        r.history_clear  = all_warm;
        return r;
    endfunction

    function automatic logic [TOD_W-1:0] hms(int h, int m, int s);
        return {h[HOUR_W-1:0], m[MIN_W-1:0], s[SEC_W-1:0]};
    endfunction

    function automatic tick_t tick_of(logic [STAMP_W-1:0] stamp, logic [TOD_W-1:0] tod,
                                      logic signed [TEMP_W-1:0] temp, logic req);
        tick_t t;
        t.now_ms = stamp;
        {t.hour, t.minute, t.second} = tod;
        t.valve_temp    = temp;
        t.drain_request = req;
        return t;
    endfunction

    task automatic send_tick(tick_t t);
        while (!calm && $urandom_range(0, 99) < 13)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid      <= 1'b1;
        now_ms        <= t.now_ms;
        hour          <= t.hour;
        minute        <= t.minute;
        second        <= t.second;
        valve_temp    <= t.valve_temp;
        drain_request <= t.drain_request;
        do
            @(posedge clk);
        while (!in_ready);
        results_due.push_back(advance_sequencer(t));
        ticks_sent++;
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        while (results_due.size() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic put_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
    endtask

    task automatic load_settings(cfg_t s);
        settle();
        put_reg(CFG_DRAIN_TIME_A, CFG_DATA_W'(s.drain_time_a));
        put_reg(CFG_DRAIN_TIME_B, CFG_DATA_W'(s.drain_time_b));
        put_reg(CFG_COLD_LIMIT, CFG_DATA_W'(s.cold_limit));
        put_reg(CFG_CRITICAL_LIMIT, CFG_DATA_W'(s.critical_limit));
        put_reg(CFG_PREHEAT_TARGET, CFG_DATA_W'(s.preheat_target));
        put_reg(CFG_PREHEAT_TIMEOUT, s.preheat_timeout_ms);
        put_reg(CFG_DRAIN_OPEN, s.drain_open_ms);
        cfg_we <= 1'b0;
        @(posedge clk);
        regs = s;
    endtask

    function automatic logic [TOD_W-1:0] random_tod();
        int m, s;
        m = $urandom_range(0, 59);
        s = $urandom_range(0, 59);
        if ($urandom_range(0, 3) == 0)
        begin
            m = 0;
            s = 0;
        end
        return hms($urandom_range(0, 23), m, s);
    endfunction

    function automatic logic signed [TEMP_W-1:0] random_limit();
        int v;
        v = TEMP_MIN + int'($urandom_range(0, TEMP_MAX - TEMP_MIN));
        return v[TEMP_W-1:0];
    endfunction

    function automatic logic [MS_W-1:0] random_span();
        case ($urandom_range(0, 3))
            0: return MS_W'($urandom_range(0, 16));
            1, 2: return MS_W'($urandom_range(0, 20000));
            default: return MS_W'($urandom_range(0, MS_MAX));
        endcase
    endfunction

    function automatic cfg_t random_settings();
        cfg_t s;
        s.drain_time_a       = random_tod();
        s.drain_time_b       = random_tod();
        s.cold_limit         = random_limit();
        s.critical_limit     = random_limit();
        s.preheat_target     = random_limit();
        s.preheat_timeout_ms = random_span();
        s.drain_open_ms      = random_span();
        return s;
    endfunction

    // temperatures cluster on the three thresholds
    function automatic logic signed [TEMP_W-1:0] pick_temp();
        int v;
        case ($urandom_range(0, 9))
            0, 1: v = regs.cold_limit + int'($urandom_range(0, 4)) - 2;
            2, 3: v = regs.critical_limit + int'($urandom_range(0, 4)) - 2;
            4, 5: v = regs.preheat_target + int'($urandom_range(0, 4)) - 2;
            6: v = int'($urandom_range(0, 4095)) - 2048;
            default: v = TEMP_MIN + int'($urandom_range(0, TEMP_MAX - TEMP_MIN));
        endcase
        return v[TEMP_W-1:0];
    endfunction

    function automatic logic signed [TEMP_W-1:0] sweep_temp();
        int lo, v;
        lo = int'(regs.cold_limit);
        if ($urandom_range(0, 99) < 15)
            return pick_temp();
        v = lo + int'($urandom_range(0, TEMP_MAX - lo));
        return v[TEMP_W-1:0];
    endfunction

    // timestamps step on the scale of the timers, with hits on their exact edges
    function automatic logic [STAMP_W-1:0] next_stamp();
        logic [STAMP_W-1:0] span;
        span = STAMP_W'($urandom_range(0, 1) ? regs.preheat_timeout_ms : regs.drain_open_ms);
        case ($urandom_range(0, 19))
            0: wall_ms = $urandom();
            1: ;
            2: wall_ms = valve_t0 + regs.drain_open_ms - 1 + $urandom_range(0, 1);
            3: wall_ms = heat_t0 + regs.preheat_timeout_ms + $urandom_range(0, 1);
            default: wall_ms = wall_ms + $urandom_range(0, span / 2 + 3);
        endcase
        return wall_ms;
    endfunction

    task automatic random_burst();
        int               kind, n, h;
        logic [TOD_W-1:0] tod;
        logic             req;
        kind = $urandom_range(0, 99);
        if (kind < 25)
        begin
            h = $urandom_range(0, 23);
            n = $urandom_range(4, 24);
            repeat (n)
            begin
                send_tick(tick_of(next_stamp(), hms(h, 0, 0), sweep_temp(), 1'b0));
                if ($urandom_range(0, 4) == 0)
                    send_tick(tick_of(next_stamp(), hms(h, 0, 0), pick_temp(), 1'b0));
                send_tick(tick_of(next_stamp(), hms(h, $urandom_range(0, 59),
                    $urandom_range(1, 59)), pick_temp(), $urandom_range(0, 19) == 0));
                h = (h == 23) ? 0 : h + 1;
            end
        end
        else if (kind < 75)
        begin
            req = ($urandom_range(0, 3) == 0);
            case ($urandom_range(0, 2))
                0: tod = regs.drain_time_a;
                1: tod = regs.drain_time_b;
                default:
                begin
                    tod = random_tod();
                    req = 1'b1;
                end
            endcase
            send_tick(tick_of(next_stamp(), tod, pick_temp(), req));
            n = $urandom_range(1, 8);
            repeat (n)
            begin
                if ($urandom_range(0, 4) != 0)
                    tod = random_tod();
                send_tick(tick_of(next_stamp(), tod, pick_temp(), $urandom_range(0, 9) == 0));
            end
        end
        else
        begin
            n = $urandom_range(1, 6);
            repeat (n)
                send_tick(tick_of($urandom_range(0, 3) == 0 ? $urandom() : next_stamp(),
                    TOD_W'($urandom_range(0, 2**TOD_W - 1)),
                    TEMP_W'($urandom_range(0, 4095)),
                    $urandom_range(0, 1) == 1));
        end
    endtask

    task automatic run_random(int count);
        int target;
        target = ticks_sent + count;
        while (ticks_sent < target)
            random_burst();
    endtask

    // cold abort, preheat, abort while heating, timeout, valve timing, hourly sample
    task automatic test_directed_paths();
        send_tick(tick_of(5, hms(1, 2, 3), -12'sd880, 1'b1));
        send_tick(tick_of(6, hms(1, 2, 3), -12'sd880, 1'b1));
        send_tick(tick_of(10, hms(1, 2, 4), 12'sd40, 1'b1));
        send_tick(tick_of(20, hms(1, 2, 5), -12'sd100, 1'b0));
        send_tick(tick_of(3600011, hms(1, 2, 6), 12'sd50, 1'b1));
        send_tick(tick_of(3600012, hms(1, 2, 7), 12'sd50, 1'b1));
        send_tick(tick_of(3600013, hms(1, 2, 8), 12'sd2000, 1'b0));
        send_tick(tick_of(3610012, hms(1, 2, 9), 12'sd0, 1'b0));
        send_tick(tick_of(3610013, hms(1, 2, 10), 12'sd0, 1'b0));
        send_tick(tick_of(32'hFFFF_FFFF, hms(0, 0, 0), 12'sh7FF, 1'b0));
        send_tick(tick_of(0, hms(0, 0, 0), 12'sh800, 1'b0));
        send_tick(tick_of(9999, hms(0, 0, 1), 12'sd0, 1'b0));
        send_tick(tick_of(10000, hms(31, 0, 0), 12'sh800, 1'b0));
        send_tick(tick_of(10001, hms(31, 63, 63), 12'sh7FF, 1'b1));
        send_tick(tick_of(10002, hms(23, 59, 59), -12'sd880, 1'b0));
        send_tick(tick_of(10003, hms(23, 0, 0), -12'sd880, 1'b0));
        send_tick(tick_of(10004, hms(23, 0, 0), 12'sd100, 1'b1));
        send_tick(tick_of(20003, hms(23, 0, 1), -12'sd880, 1'b1));
        send_tick(tick_of(20004, hms(23, 0, 2), 12'sd0, 1'b0));
    endtask

    // zero open time and zero timeout, matches on both drain slots
    task automatic test_zero_times();
        cfg_t s;
        s = regs;
        s.drain_time_a       = hms(3, 4, 5);
        s.drain_time_b       = TOD_W'(TOD_MAX);
        s.preheat_timeout_ms = '0;
        s.drain_open_ms      = '0;
        load_settings(s);
        send_tick(tick_of(50000, hms(23, 59, 59), 12'sd100, 1'b0));
        send_tick(tick_of(50001, hms(23, 0, 0), 12'sd500, 1'b0));
        send_tick(tick_of(50002, hms(3, 4, 5), 12'sd0, 1'b0));
        send_tick(tick_of(50003, hms(23, 0, 1), 12'sd0, 1'b0));
        send_tick(tick_of(50004, hms(5, 0, 0), -12'sd880, 1'b0));
        send_tick(tick_of(50005, hms(3, 4, 5), 12'sd10, 1'b0));
        send_tick(tick_of(50006, hms(3, 4, 6), 12'sd10, 1'b0));
    endtask

    task automatic test_default_random();
        cfg_t s;
        s.drain_time_a       = '0;
        s.drain_time_b       = '0;
        s.cold_limit         = RST_COLD_LIMIT;
        s.critical_limit     = RST_CRITICAL_LIMIT;
        s.preheat_target     = RST_PREHEAT_TARGET;
        s.preheat_timeout_ms = MS_W'(5000);
        s.drain_open_ms      = MS_W'(2000);
        load_settings(s);
        run_random(100);
        calm = 1'b1;
        run_random(150);
        calm = 1'b0;
        run_random(100);
    endtask

    task automatic test_extreme_settings();
        cfg_t s;
        s.drain_time_a       = '0;
        s.drain_time_b       = TOD_W'(TOD_MAX);
        s.cold_limit         = TEMP_W'(TEMP_MAX);
        s.critical_limit     = TEMP_W'(TEMP_MIN);
        s.preheat_target     = TEMP_W'(TEMP_MAX);
        s.preheat_timeout_ms = MS_W'(MS_MAX);
        s.drain_open_ms      = MS_W'(MS_MAX);
        load_settings(s);
        run_random(150);
        s.drain_time_a       = TOD_W'(TOD_MAX);
        s.drain_time_b       = '0;
        s.cold_limit         = TEMP_W'(TEMP_MIN);
        s.critical_limit     = TEMP_W'(TEMP_MAX);
        s.preheat_target     = TEMP_W'(TEMP_MIN);
        s.preheat_timeout_ms = '0;
        s.drain_open_ms      = '0;
        load_settings(s);
        run_random(150);
    endtask

    task automatic test_random_settings();
        repeat (6)
        begin
            load_settings(random_settings());
            run_random(120);
        end
    endtask

    initial
    begin
        clear_sequencer_state();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_paths();
        test_zero_times();
        test_default_random();
        test_extreme_settings();
        test_random_settings();
        settle();
        if (mismatches == 0 && results_due.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
